>>> hdl/ioae_pkg.sv
// ============================================================================
// IPv4 option address extractor: shared package
// Word types for both channels, result status codes, register indexes and
// the fixed sizes of the IPv4 header.
// ============================================================================
package ioae_pkg;

  // Fixed header geometry.
  localparam int unsigned BaseWords  = 5;
  localparam int unsigned WordBytes  = 4;
  localparam int unsigned BaseBytes  = BaseWords * WordBytes;
  localparam int unsigned MinOptLen  = 2;

  // Configuration port widths.
  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 8;

  // Register indexes.
  localparam logic [CfgIndexW-1:0] CFG_OPTION_TYPE = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_OPTION_SIZE = 1'b1;

  // Register reset values.
  localparam logic [7:0] OptionTypeReset = 8'd31;
  localparam logic [5:0] OptionSizeReset = 6'd8;

  // Scan outcome codes.
  localparam logic [1:0] STATUS_NONE    = 2'd0;
  localparam logic [1:0] STATUS_FOUND   = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  // One header byte.
  typedef struct packed {
    logic [7:0] header_byte;
    logic       header_start;
  } in_word_t;

  // One scan result.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] source_port;
    logic [31:0] source_address;
  } out_word_t;

endpackage

>>> hdl/ioae_parser.sv
// ============================================================================
// IPv4 option address extractor: header parser
// Holds the per-header scan state and updates it from one accepted header byte
// per cycle. On the last header byte it offers the scan result for one cycle.
// ============================================================================
module ioae_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  ioae_pkg::in_word_t  in_data_i,
  input  logic [7:0]          option_type_i,
  input  logic [5:0]          option_size_i,
  output logic                res_valid_o,
  output ioae_pkg::out_word_t res_data_o
);
  import ioae_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BASE,
    PH_TYPE,
    PH_LEN,
    PH_BODY,
    PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [5:0]  pos_q, pos_d;
  logic [5:0]  total_q, total_d;
  logic [5:0]  left_q, left_d;
  logic        capt_q, capt_d;
  logic [15:0] port_q, port_d;
  logic [31:0] addr_q, addr_d;
  logic [1:0]  status_q, status_d;

  logic [7:0]  b;
  logic [3:0]  words;
  logic [5:0]  left_here;
  logic [7:0]  left_p1;
  logic [5:0]  len_left;
  logic        len_match;
  logic [5:0]  offset;
  logic [5:0]  body_left;
  logic        active;
  logic [5:0]  pos_cur;
  logic [6:0]  pos_next;

  assign b         = in_data_i.header_byte;
  assign left_here = total_q - pos_q;
  assign left_p1   = {2'b00, left_here} + 8'd1;
  assign len_left  = b[5:0] - 6'(MinOptLen);
  assign len_match = capt_q && (b == {2'b00, option_size_i});
  assign offset    = option_size_i - left_q;
  assign body_left = left_q - 6'd1;

  // Next-state logic for one accepted byte.
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    total_d     = total_q;
    left_d      = left_q;
    capt_d      = capt_q;
    port_d      = port_q;
    addr_d      = addr_q;
    status_d    = status_q;
    words       = b[3:0];
    active      = 1'b0;
    pos_cur     = pos_q;
    pos_next    = 7'd0;
    res_valid_o = 1'b0;

    if (accept_i) begin
      priority if (in_data_i.header_start) begin
        // A start byte always opens a fresh header.
        if (words < 4'(BaseWords)) begin
          words = 4'(BaseWords);
        end
        total_d  = 6'(words * WordBytes);
        pos_cur  = 6'd0;
        phase_d  = PH_BASE;
        left_d   = 6'd0;
        capt_d   = 1'b0;
        port_d   = 16'd0;
        addr_d   = 32'd0;
        status_d = STATUS_NONE;
        active   = 1'b1;
      end else if (phase_q != PH_IDLE) begin
        active = 1'b1;
        unique case (phase_q)
          PH_TYPE: begin
            if (b == 8'd0) begin
              // End of option list.
              status_d = STATUS_NONE;
              phase_d  = PH_DONE;
              capt_d   = 1'b0;
            end else if (b == 8'd1) begin
              // No-operation byte: stay on type.
            end else if (left_here < 6'(MinOptLen)) begin
              status_d = STATUS_INVALID;
              phase_d  = PH_DONE;
              capt_d   = 1'b0;
            end else begin
              capt_d  = (b == option_type_i);
              phase_d = PH_LEN;
            end
          end
          PH_LEN: begin
            if (b < 8'(MinOptLen) || b > left_p1) begin
              status_d = STATUS_INVALID;
              phase_d  = PH_DONE;
              capt_d   = 1'b0;
            end else begin
              capt_d = len_match;
              left_d = len_left;
              if (len_left == 6'd0) begin
                if (len_match) begin
                  status_d = STATUS_FOUND;
                  phase_d  = PH_DONE;
                  capt_d   = 1'b0;
                end else begin
                  phase_d = PH_TYPE;
                end
              end else begin
                phase_d = PH_BODY;
              end
            end
          end
          PH_BODY: begin
            if (capt_q) begin
              if (offset == 6'd2 || offset == 6'd3) begin
                port_d = {port_q[7:0], b};
              end else if (offset >= 6'd4 && offset <= 6'd7) begin
                addr_d = {addr_q[23:0], b};
              end
            end
            left_d = body_left;
            if (body_left == 6'd0) begin
              if (capt_q) begin
                status_d = STATUS_FOUND;
                phase_d  = PH_DONE;
                capt_d   = 1'b0;
              end else begin
                phase_d = PH_TYPE;
              end
            end
          end
          default: begin
            // Fixed header bytes and bytes after a stop are only counted.
          end
        endcase
      end else begin
        // Bytes outside a header are dropped.
      end

      // Byte counting and the end of the header.
      if (active) begin
        pos_next = {1'b0, pos_cur} + 7'd1;
        if (pos_next == {1'b0, total_d}) begin
          res_valid_o = 1'b1;
          phase_d     = PH_IDLE;
          pos_d       = 6'd0;
        end else begin
          pos_d = pos_next[5:0];
          if (phase_d == PH_BASE && pos_d == 6'(BaseBytes)) begin
            phase_d = PH_TYPE;
          end
        end
      end
    end
  end

  // The result carries the capture only when the option was found.
  always_comb begin
    res_data_o.status         = status_d;
    res_data_o.source_port    = (status_d == STATUS_FOUND) ? port_d : 16'd0;
    res_data_o.source_address = (status_d == STATUS_FOUND) ? addr_d : 32'd0;
  end

  // Scan state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pos_q    <= 6'd0;
      total_q  <= 6'd0;
      left_q   <= 6'd0;
      capt_q   <= 1'b0;
      port_q   <= 16'd0;
      addr_q   <= 32'd0;
      status_q <= STATUS_NONE;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      total_q  <= total_d;
      left_q   <= left_d;
      capt_q   <= capt_d;
      port_q   <= port_d;
      addr_q   <= addr_d;
      status_q <= status_d;
    end
  end

endmodule

>>> hdl/ioae_skid.sv
// ============================================================================
// IPv4 option address extractor: result buffer
// Output register with one skid entry, so that a result can be taken in
// while an earlier one still waits on a stalled output.
// ============================================================================
module ioae_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ioae_pkg::out_word_t push_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ioae_pkg::out_word_t out_data_o
);
  import ioae_pkg::*;

  logic      out_valid_q;
  out_word_t out_q;
  logic      skid_valid_q;
  out_word_t skid_q;
  logic      pop;

  assign pop         = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (push_i && out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else if (push_i) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    priority if (push_i && out_valid_q && !pop) begin
      skid_q <= push_data_i;
    end else if (push_i) begin
      out_q <= push_data_i;
    end else if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

endmodule

>>> hdl/ipv4_option_address_extractor.sv
// ============================================================================
// IPv4 option address extractor
// Scans the option list of an IPv4 header, one byte a cycle unless stalled,
// and reports whether the configured address option is present, with its port
// and address when it is.
// ============================================================================
//
//   Channel | Direction | Handshake                 | Word
//   --------+-----------+---------------------------+--------------------------
//   in      | input     | in_valid_i / in_stall_o   | header_byte, header_start
//   out     | output    | out_valid_o / out_stall_i | status, port, address
//   cfg     | input     | cfg_we_i                  | option_type, option_size
//
// One header byte is accepted per cycle unless the input stalls; the parser
// state update is a single register-to-register step. A result is offered by
// the output register, via the skid entry if needed, until it is taken. Reset
// clears all scan state and loads the register defaults. The input stalls
// only while both the output register and its skid entry hold results.
//
module ipv4_option_address_extractor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ioae_pkg::in_word_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ioae_pkg::out_word_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [ioae_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [ioae_pkg::CfgDataW-1:0]     cfg_data_i
);
  import ioae_pkg::*;

  logic [7:0] option_type_q;
  logic [5:0] option_size_q;
  logic       in_accept;
  logic       res_valid;
  out_word_t  res_data;
  logic       skid_full;

  assign in_stall_o = skid_full;
  assign in_accept  = in_valid_i && !skid_full;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      option_type_q <= OptionTypeReset;
      option_size_q <= OptionSizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OPTION_TYPE: option_type_q <= cfg_data_i;
        CFG_OPTION_SIZE: option_size_q <= cfg_data_i[5:0];
        default: begin
        end
      endcase
    end
  end

  // Header parser.
  ioae_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .in_data_i     (in_data_i),
    .option_type_i (option_type_q),
    .option_size_i (option_size_q),
    .res_valid_o   (res_valid),
    .res_data_o    (res_data)
  );

  // Result buffer.
  ioae_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res_data),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // The input only stalls behind a waiting result.
  a_stall_needs_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o
  ) else $error("input stalled with no result waiting");

  // A full skid entry is only reached through a stalled output.
  a_stall_after_block : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i)
  ) else $error("skid entry filled without a stalled output");

  // Only the three defined outcomes are reported.
  a_status_code : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == STATUS_NONE ||
                     out_data_o.status == STATUS_FOUND ||
                     out_data_o.status == STATUS_INVALID)
  ) else $error("undefined status code");

  // Capture fields are clear unless the option was found.
  a_capture_clear : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != STATUS_FOUND) |->
      (out_data_o.source_port == 16'd0 && out_data_o.source_address == 32'd0)
  ) else $error("capture fields set without a found option");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// IPv4 option address extractor testbench
// Feeds IPv4 headers a byte at a time and predicts the scan outcome of each
// header. Directed headers cover the header length limits, end-of-list,
// no-op, malformed lengths, stray bytes, restarts and unusual option sizes.
// Random headers, mostly well-formed option lists with random content and
// some corrupted ones, then run under several register settings. Both
// channels idle at random, and every result is checked field by field.
// ============================================================================
module testbench;
  import ioae_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_FIXED, SCAN_TYPE, SCAN_LENGTH, SCAN_BODY, SCAN_STOPPED
  } scan_phase_e;

  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseBytes   = 80;
  localparam int unsigned PhaseHeaders = 3;

  // Option list codes and the capture window inside an option.
  localparam logic [7:0] OPT_END = 8'd0;
  localparam logic [7:0] OPT_NOP = 8'd1;
  localparam logic [5:0] PortFirst = 6'd2;
  localparam logic [5:0] PortLast  = 6'd3;
  localparam logic [5:0] AddrFirst = 6'd4;
  localparam logic [5:0] AddrLast  = 6'd7;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_word_t             in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_word_t            out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i  = '0;

  // Predicted register contents and scan state.
  logic [7:0]  want_type  = OptionTypeReset;
  logic [5:0]  want_size  = OptionSizeReset;
  logic [5:0]  hdr_len    = '0;
  logic [5:0]  hdr_pos    = '0;
  logic [5:0]  opt_left   = '0;
  scan_phase_e scan_phase = SCAN_IDLE;
  logic        matching   = 1'b0;
  logic [15:0] port_acc   = '0;
  logic [31:0] addr_acc   = '0;
  logic [1:0]  scan_state = STATUS_NONE;
  out_word_t   scan_results_q[$];

  // Header under construction and run bookkeeping.
  logic [7:0] hdr_q[$];
  int         hdr_goal;
  bit         in_gaps_on    = 1'b1;
  bit         out_stalls_on = 1'b1;
  int         stall_run     = 0;
  int         quiet_cycles  = 0;
  int         error_count   = 0;
  int         bytes_taken   = 0;
  int         headers_sent  = 0;
  int         settings_used = 0;
  int         found_count   = 0;
  int         none_count    = 0;
  int         invalid_count = 0;

  ipv4_option_address_extractor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // The receiver stalls in bursts of random length.
  always @(negedge clk_i) begin
    if (stall_run > 0) begin
      stall_run--;
    end else if (out_stalls_on && $urandom_range(0, 7) == 0) begin
      stall_run = $urandom_range(1, 10);
    end
    out_stall_i <= out_stalls_on && (stall_run > 0);
  end

  // Scan predictor.
  function automatic void stop_scan(input logic [1:0] outcome);
    scan_state = outcome;
    scan_phase = SCAN_STOPPED;
    matching   = 1'b0;
  endfunction

  function automatic void close_option();
    if (matching) begin
      stop_scan(STATUS_FOUND);
    end else begin
      scan_phase = SCAN_TYPE;
    end
  endfunction

  task automatic predict_byte(input in_word_t w);
    logic [5:0] left_here;
    logic [5:0] offset;
    logic [3:0] words;
    out_word_t  res;
    left_here = hdr_len - hdr_pos;
    if (w.header_start) begin
      // A start byte always opens a new header, dropping any old one.
      words      = (w.header_byte[3:0] < BaseWords) ? 4'(BaseWords) : w.header_byte[3:0];
      hdr_len    = {words, 2'b00};
      hdr_pos    = '0;
      scan_phase = SCAN_FIXED;
      opt_left   = '0;
      matching   = 1'b0;
      port_acc   = '0;
      addr_acc   = '0;
      scan_state = STATUS_NONE;
    end else if (scan_phase == SCAN_IDLE) begin
      return;
    end else begin
      case (scan_phase)
        SCAN_TYPE: begin
          if (w.header_byte == OPT_END) begin
            stop_scan(STATUS_NONE);
          end else if (w.header_byte == OPT_NOP) begin
            matching = matching;
          end else if (left_here < MinOptLen) begin
            stop_scan(STATUS_INVALID);
          end else begin
            matching   = (w.header_byte == want_type);
            scan_phase = SCAN_LENGTH;
          end
        end
        SCAN_LENGTH: begin
          // The length counts from the type byte, so one more byte is allowed.
          if (w.header_byte < MinOptLen || w.header_byte > {2'b00, left_here} + 8'd1) begin
            stop_scan(STATUS_INVALID);
          end else begin
            if (matching && w.header_byte != {2'b00, want_size}) matching = 1'b0;
            opt_left = 6'(w.header_byte - 8'd2);
            if (opt_left == '0) begin
              close_option();
            end else begin
              scan_phase = SCAN_BODY;
            end
          end
        end
        SCAN_BODY: begin
          if (matching) begin
            offset = want_size - opt_left;
            if (offset == PortFirst || offset == PortLast) begin
              port_acc = {port_acc[7:0], w.header_byte};
            end else if (offset >= AddrFirst && offset <= AddrLast) begin
              addr_acc = {addr_acc[23:0], w.header_byte};
            end
          end
          opt_left = opt_left - 6'd1;
          if (opt_left == '0) close_option();
        end
        default: begin
          matching = matching;
        end
      endcase
    end
    if ({1'b0, hdr_pos} + 7'd1 == {1'b0, hdr_len}) begin
      res.status         = scan_state;
      res.source_port    = (scan_state == STATUS_FOUND) ? port_acc : '0;
      res.source_address = (scan_state == STATUS_FOUND) ? addr_acc : '0;
      scan_results_q.push_back(res);
      scan_phase = SCAN_IDLE;
      hdr_pos    = '0;
    end else begin
      hdr_pos = hdr_pos + 6'd1;
      if (scan_phase == SCAN_FIXED && hdr_pos == BaseBytes) scan_phase = SCAN_TYPE;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
    if (actual !== expected) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expected, actual);
    end
  endtask

  // Predicts on every accepted byte, checks every accepted result and
  // watches for both channels having stopped moving.
  always @(posedge clk_i) begin : result_monitor
    out_word_t want;
    bit        moved;
    moved = 1'b0;
    if (in_valid_i && !in_stall_o) begin
      predict_byte(in_data_i);
      bytes_taken++;
      moved = 1'b1;
    end
    if (out_valid_o && !out_stall_i) begin
      moved = 1'b1;
      if (scan_results_q.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected, expected nothing, got %p", $time,
                 out_data_o);
      end else begin
        want = scan_results_q.pop_front();
        compare_field("status", 32'(want.status), 32'(out_data_o.status));
        compare_field("source_port", 32'(want.source_port), 32'(out_data_o.source_port));
        compare_field("source_address", want.source_address, out_data_o.source_address);
        case (want.status)
          STATUS_FOUND: found_count++;
          STATUS_NONE:  none_count++;
          default:      invalid_count++;
        endcase
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, QuietLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sends one byte; returns at the edge that accepted it with valid still high.
  task automatic send_byte(input logic [7:0] value, input logic first);
    int gap;
    @(negedge clk_i);
    if (in_gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{header_byte: value, header_start: first};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic stop_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Stops the input, lets every expected result arrive, then lets the design settle.
  task automatic drain_results();
    stop_input();
    while (scan_results_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] index, input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == CFG_OPTION_TYPE) begin
      want_type = value;
    end else begin
      want_size = value[5:0];
    end
  endtask

  task automatic set_options(input logic [7:0] kind, input logic [5:0] size);
    drain_results();
    write_reg(CFG_OPTION_TYPE, kind);
    write_reg(CFG_OPTION_SIZE, {2'b00, size});
    settings_used++;
  endtask

  // Header construction.
  function automatic void start_header(input logic [3:0] ihl);
    hdr_q.delete();
    hdr_goal = ((ihl < BaseWords) ? BaseWords : ihl) * WordBytes;
    hdr_q.push_back({4'($urandom), ihl});
    while (hdr_q.size() < BaseBytes) hdr_q.push_back(8'($urandom));
  endfunction

  function automatic void add_option(input logic [7:0] kind, input int len);
    hdr_q.push_back(kind);
    hdr_q.push_back(8'(len));
    repeat (len - 2) hdr_q.push_back(8'($urandom));
  endfunction

  function automatic void fill_options(input logic [7:0] value);
    while (hdr_q.size() < hdr_goal) hdr_q.push_back(value);
  endfunction

  function automatic void fill_random();
    while (hdr_q.size() < hdr_goal) hdr_q.push_back(8'($urandom));
  endfunction

  // Mostly well-formed option lists; a fifth of those with options get one byte corrupted.
  function automatic void random_header();
    int pick;
    int room;
    int ihl;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      ihl = $urandom_range(0, 4);
    end else if (pick < 4) begin
      ihl = $urandom_range(11, 15);
    end else begin
      ihl = $urandom_range(5, 10);
    end
    start_header(4'(ihl));
    while (hdr_q.size() < hdr_goal) begin
      room = hdr_goal - hdr_q.size();
      pick = $urandom_range(0, 15);
      if (pick < 2) begin
        hdr_q.push_back(OPT_NOP);
      end else if (pick == 2) begin
        hdr_q.push_back(OPT_END);
      end else if (pick < 6 && want_size >= MinOptLen && room >= want_size) begin
        add_option(want_type, want_size);
      end else if (room >= 2) begin
        add_option(8'($urandom_range(2, 255)), $urandom_range(2, (room < 12) ? room : 12));
      end else begin
        hdr_q.push_back(8'($urandom));
      end
    end
    if (hdr_goal > BaseBytes && $urandom_range(0, 4) == 0) begin
      hdr_q[$urandom_range(BaseBytes, hdr_goal - 1)] = 8'($urandom);
    end
  endfunction

  // Sends the first count bytes of the built header.
  task automatic send_header(input int count);
    for (int i = 0; i < count; i++) send_byte(hdr_q[i], i == 0);
    headers_sent++;
  endtask

  task automatic send_stray(input int count);
    repeat (count) send_byte(8'($urandom), 1'b0);
  endtask

  // Well-formed headers under the reset register values.
  task automatic check_basic_headers();
    start_header(4'd5);
    send_header(hdr_q.size());
    // Length nibbles below five are read as a plain 20-byte header.
    start_header(4'd0);
    send_header(hdr_q.size());
    start_header(4'd4);
    send_header(hdr_q.size());
    // No-ops, then the wanted option; the bytes after a match are ignored.
    start_header(4'd8);
    hdr_q.push_back(OPT_NOP);
    hdr_q.push_back(OPT_NOP);
    add_option(OptionTypeReset, OptionSizeReset);
    fill_options(8'hFF);
    send_header(hdr_q.size());
    // Longest header, with the wanted option in its very last bytes.
    start_header(4'd15);
    add_option(8'd7, 32);
    add_option(OptionTypeReset, OptionSizeReset);
    send_header(hdr_q.size());
    // Right type with the wrong length is passed over.
    start_header(4'd9);
    add_option(OptionTypeReset, 6);
    add_option(OptionTypeReset, OptionSizeReset);
    fill_options(OPT_NOP);
    send_header(hdr_q.size());
  endtask

  task automatic check_malformed_lists();
    // End of list stops the scan even though the wanted option follows.
    start_header(4'd7);
    hdr_q.push_back(OPT_END);
    add_option(OptionTypeReset, OptionSizeReset);
    fill_random();
    send_header(hdr_q.size());
    // A type byte with only one byte left.
    start_header(4'd6);
    repeat (3) hdr_q.push_back(OPT_NOP);
    hdr_q.push_back(8'd7);
    send_header(hdr_q.size());
    // Lengths of zero and one, and one that runs past the header.
    start_header(4'd6);
    hdr_q.push_back(8'd7);
    hdr_q.push_back(8'd1);
    fill_random();
    send_header(hdr_q.size());
    start_header(4'd6);
    hdr_q.push_back(8'd9);
    hdr_q.push_back(8'd0);
    fill_random();
    send_header(hdr_q.size());
    start_header(4'd6);
    hdr_q.push_back(8'd7);
    hdr_q.push_back(8'd5);
    fill_random();
    send_header(hdr_q.size());
    // An option that exactly fills the header is fine.
    start_header(4'd6);
    add_option(8'd7, 4);
    send_header(hdr_q.size());
  endtask

  task automatic check_stray_and_restart();
    // Bytes without a start outside a header are ignored.
    send_stray(3);
    // A start byte part way through drops the header without a result.
    start_header(4'd7);
    send_header(10);
    start_header(4'd5);
    send_header(hdr_q.size());
    start_header(4'd8);
    add_option(OptionTypeReset, OptionSizeReset);
    fill_options(OPT_NOP);
    send_header(hdr_q.size() - 1);
    start_header(4'd6);
    add_option(OptionTypeReset, OptionSizeReset - 4);
    send_header(hdr_q.size());
    send_stray(2);
  endtask

  task automatic check_capture_sizes();
    // An option longer than eight bytes: only bytes two to seven are kept.
    set_options(8'hFF, 6'd12);
    start_header(4'd9);
    add_option(8'hFF, 12);
    fill_options(OPT_NOP);
    send_header(hdr_q.size());
    // Smallest size: a match with nothing captured.
    set_options(8'd2, 6'd2);
    start_header(4'd6);
    hdr_q.push_back(OPT_NOP);
    add_option(8'd2, 2);
    fill_random();
    send_header(hdr_q.size());
    // Largest size filling the whole option area.
    set_options(8'hFF, 6'd40);
    start_header(4'd15);
    add_option(8'hFF, 40);
    send_header(hdr_q.size());
    // Sizes outside two to forty can never match.
    set_options(OptionTypeReset, 6'd0);
    start_header(4'd8);
    add_option(OptionTypeReset, OptionSizeReset);
    fill_options(OPT_NOP);
    send_header(hdr_q.size());
    set_options(OptionTypeReset, 6'd63);
    start_header(4'd15);
    add_option(OptionTypeReset, 40);
    send_header(hdr_q.size());
  endtask

  task automatic run_random_phase(input logic [7:0] kind, input logic [5:0] size,
                                  input bit allow_idle);
    int first_byte;
    int first_header;
    int pick;
    set_options(kind, size);
    in_gaps_on    = allow_idle && ($urandom_range(0, 3) != 0);
    out_stalls_on = allow_idle && ($urandom_range(0, 3) != 0);
    first_byte    = bytes_taken;
    first_header  = headers_sent;
    while (bytes_taken - first_byte < PhaseBytes || headers_sent - first_header < PhaseHeaders)
    begin
      pick = $urandom_range(0, 19);
      if (pick == 0) send_stray($urandom_range(1, 4));
      random_header();
      if (pick == 1) begin
        send_header($urandom_range(1, hdr_q.size() - 1));
      end else begin
        send_header(hdr_q.size());
      end
      // Now and then hold off until every result is back.
      if (pick == 2 && allow_idle) drain_results();
    end
  endtask

  task automatic run_random_traffic();
    run_random_phase(OptionTypeReset, OptionSizeReset, 1'b1);
    run_random_phase(8'hFF, 6'd40, 1'b1);
    run_random_phase(8'd2, 6'd2, 1'b1);
    run_random_phase(8'($urandom_range(2, 255)), 6'($urandom_range(3, 12)), 1'b1);
    run_random_phase(OPT_END, 6'd0, 1'b1);
  endtask

  // Last stretch at full rate on both channels.
  task automatic run_quiet_tail();
    run_random_phase(OptionTypeReset, OptionSizeReset, 1'b0);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    check_basic_headers();
    check_malformed_lists();
    check_stray_and_restart();
    check_capture_sizes();
    run_random_traffic();
    run_quiet_tail();
    drain_results();
    repeat (10) @(negedge clk_i);
    if (scan_results_q.size() != 0) begin
      error_count += scan_results_q.size();
      $display("%0t: %0d results never arrived, expected %p, got nothing", $time,
               scan_results_q.size(), scan_results_q[0]);
    end
    $display("Scanned %0d headers from %0d accepted bytes under %0d register settings.",
             headers_sent, bytes_taken, settings_used);
    $display("Results seen: %0d found, %0d with no option, %0d malformed; %0d errors.",
             found_count, none_count, invalid_count, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
